/* rtl/segregated_free_list_allocator_core_assert.svh */
// Assertion macros for the allocator core.
// IMPLY checks a same-cycle implication, NEXT checks it in the following cycle.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFLA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfla assertion failed");
`define SFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfla assertion failed");
`else
`define SFLA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sfla_pkg.sv */
package sfla_pkg;

  // fixed field widths
  localparam int OP_W     = 1;
  localparam int SIZE_W   = 8;
  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;
  localparam int CLASS_W  = 2;

  localparam int NUM_CLASSES     = 4;
  localparam int MIN_CLASS_BYTES = 8;
  localparam int MAX_REQUEST     = 64;
  localparam int LIMIT_RESET     = 1024;

  // parameter defaults
  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int NUM_BLOCKS_DEF   = 8;
  localparam int HEADER_BYTES_DEF = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_MEM    = 2'd2
  } status_t;

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // header plus payload bytes of one block of class c
  function automatic int full_bytes(input int c, input int hdr);
    return (MIN_CLASS_BYTES << c) + hdr;
  endfunction

  function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [CLASS_W-1:0] c;
    if (size <= SIZE_W'(8))       c = 2'd0;
    else if (size <= SIZE_W'(16)) c = 2'd1;
    else if (size <= SIZE_W'(32)) c = 2'd2;
    else                          c = 2'd3;
    return c;
  endfunction

endpackage

/* rtl/sfla_ram.sv */
module sfla_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/sfla_alu.sv */
// Shared adder with an over-bound compare.
module sfla_alu #(
  parameter int W = 12
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] bound,
  output logic [W-1:0] sum,
  output logic         over
);

  assign sum  = a + b;
  assign over = (sum > bound);

endmodule

/* rtl/segregated_free_list_allocator_core.sv */
// An accepted item passes CHECK, POP_RD, POP_WR, RESP (allocate from a non-empty
// list), CHECK, FREE_RD, FREE_WR, RESP (valid free) or CHECK, RESP (oversize, out
// of memory, ignored free); a slab carve first adds CARVE, one header write per block.
// One item at a time, taken again as the result comes out; RESP waits on a stall.
// Reset (synchronous, rst_n low): lists empty, heap_used 0, heap_limit 1024;
// the header RAM is not cleared.
module segregated_free_list_allocator_core #(
  parameter int HEAP_BYTES   = sfla_pkg::HEAP_BYTES_DEF,
  parameter int NUM_BLOCKS   = sfla_pkg::NUM_BLOCKS_DEF,
  parameter int HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sfla_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfla_pkg::OP_W-1:0]     in_operation,
  input  logic [sfla_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [sfla_pkg::ADDR_W-1:0]   in_block_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfla_pkg::ADDR_W-1:0]   out_payload_address,
  output logic [sfla_pkg::STATUS_W-1:0] out_status
);

`include "segregated_free_list_allocator_core_assert.svh"

  localparam int NC     = sfla_pkg::NUM_CLASSES;
  localparam int CLW    = sfla_pkg::CLASS_W;
  localparam int DEPTH  = HEAP_BYTES / 8;
  localparam int IW     = $clog2(DEPTH);
  localparam int OW     = $clog2(HEAP_BYTES + 1);
  localparam int EW     = CLW + OW;
  localparam int CW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int FULL0  = sfla_pkg::full_bytes(0, HEADER_BYTES);
  localparam int FULL1  = sfla_pkg::full_bytes(1, HEADER_BYTES);
  localparam int FULL2  = sfla_pkg::full_bytes(2, HEADER_BYTES);
  localparam int FULL3  = sfla_pkg::full_bytes(3, HEADER_BYTES);
  localparam int SW     = sfla_pkg::max_i($clog2(HEAP_BYTES + FULL3 * NUM_BLOCKS + 1),
                                          sfla_pkg::CFG_W);
  localparam int FULL_B [NC] = '{FULL0, FULL1, FULL2, FULL3};
  localparam int SLAB_B [NC] = '{FULL0 * NUM_BLOCKS, FULL1 * NUM_BLOCKS,
                                 FULL2 * NUM_BLOCKS, FULL3 * NUM_BLOCKS};

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_CHECK   = 8'b0000_0010,
    ST_CARVE   = 8'b0000_0100,
    ST_POP_RD  = 8'b0000_1000,
    ST_POP_WR  = 8'b0001_0000,
    ST_FREE_RD = 8'b0010_0000,
    ST_FREE_WR = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_t;

  // header entry index of a payload offset
  function automatic logic [IW-1:0] hdr_idx(input logic [OW-1:0] p);
    logic [OW-1:0] d;
    d = p - OW'(HEADER_BYTES);
    return d[IW+2:3];
  endfunction

  state_t                           state_r, state_nxt;
  logic [sfla_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [sfla_pkg::SIZE_W-1:0]      size_r, size_nxt;
  logic [SW-1:0]                    addr_r, addr_nxt;
  logic [CLW-1:0]                   cls_r, cls_nxt;
  logic [OW-1:0]                    head_r [NC];
  logic [OW-1:0]                    head_nxt [NC];
  logic [OW-1:0]                    used_r, used_nxt;
  logic [sfla_pkg::CFG_W-1:0]       limit_r;
  logic [OW-1:0]                    p_r, p_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [OW-1:0]                    res_addr_r, res_addr_nxt;
  sfla_pkg::status_t                res_status_r, res_status_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [sfla_pkg::ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  sfla_pkg::status_t                out_status_r, out_status_nxt;

  logic [SW-1:0]  alu_a, alu_b, alu_bound, alu_sum;
  logic           alu_over;
  logic [SW-1:0]  lim_cfg, lim_eff;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata, mem_rdata;
  logic [CLW-1:0] rd_cls;
  logic [OW-1:0]  rd_next;
  logic [CLW-1:0] c_req;
  logic           carve_last;

  sfla_alu #(.W(SW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .bound (alu_bound),
    .sum   (alu_sum),
    .over  (alu_over)
  );

  sfla_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_hdr_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign rd_cls     = mem_rdata[EW-1:OW];
  assign rd_next    = mem_rdata[OW-1:0];
  assign c_req      = sfla_pkg::class_of(size_r);
  assign carve_last = (cnt_r == CW'(NUM_BLOCKS - 1));
  assign lim_cfg    = SW'(limit_r);
  assign lim_eff    = (lim_cfg < SW'(HEAP_BYTES)) ? lim_cfg : SW'(HEAP_BYTES);

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    cls_nxt        = cls_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    alu_a          = '0;
    alu_b          = '0;
    alu_bound      = '0;
    mem_we         = 1'b0;
    mem_waddr      = hdr_idx(p_r);
    mem_wdata      = '0;
    mem_raddr      = hdr_idx(addr_r[OW-1:0]);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          size_nxt  = in_request_size;
          addr_nxt  = SW'(in_block_address);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_addr_nxt   = '0;
        res_status_nxt = sfla_pkg::ST_OK;
        if (op_r == sfla_pkg::OP_ALLOC) begin
          cls_nxt = c_req;
          if (size_r > sfla_pkg::SIZE_W'(sfla_pkg::MAX_REQUEST)) begin
            res_status_nxt = sfla_pkg::ST_TOO_LARGE;
            state_nxt      = ST_RESP;
          end else if (head_r[c_req] == '0) begin
            // empty list: does a fresh slab fit under the limit?
            alu_a     = SW'(used_r);
            alu_b     = SW'(SLAB_B[c_req]);
            alu_bound = lim_eff;
            if (alu_over) begin
              res_status_nxt = sfla_pkg::ST_NO_MEM;
              state_nxt      = ST_RESP;
            end else begin
              p_nxt           = used_r + OW'(HEADER_BYTES);
              head_nxt[c_req] = used_r + OW'(HEADER_BYTES);
              used_nxt        = alu_sum[OW-1:0];
              cnt_nxt         = '0;
              state_nxt       = ST_CARVE;
            end
          end else begin
            state_nxt = ST_POP_RD;
          end
        end else begin
          // free is valid when HEADER_BYTES <= addr < heap_used
          alu_a     = addr_r;
          alu_b     = SW'(1);
          alu_bound = SW'(used_r);
          if (addr_r >= SW'(HEADER_BYTES) && !alu_over) begin
            state_nxt = ST_FREE_RD;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_CARVE: begin
        alu_a     = SW'(p_r);
        alu_b     = SW'(FULL_B[cls_r]);
        mem_we    = 1'b1;
        mem_waddr = hdr_idx(p_r);
        mem_wdata = {cls_r, carve_last ? {OW{1'b0}} : alu_sum[OW-1:0]};
        p_nxt     = alu_sum[OW-1:0];
        if (carve_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_POP_RD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_POP_RD: begin
        mem_raddr = hdr_idx(head_r[cls_r]);
        state_nxt = ST_POP_WR;
      end
      ST_POP_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = hdr_idx(head_r[cls_r]);
        mem_wdata       = {rd_cls, {OW{1'b0}}};
        head_nxt[cls_r] = rd_next;
        res_addr_nxt    = head_r[cls_r];
        state_nxt       = ST_RESP;
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = hdr_idx(addr_r[OW-1:0]);
        mem_wdata        = {rd_cls, head_r[rd_cls]};
        head_nxt[rd_cls] = addr_r[OW-1:0];
        state_nxt        = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = sfla_pkg::ADDR_W'(res_addr_r);
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '{default: '0};
      used_r      <= '0;
      limit_r     <= sfla_pkg::CFG_W'(sfla_pkg::LIMIT_RESET);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    cls_r        <= cls_nxt;
    p_r          <= p_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  `SFLA_ASSERT_IMPLY(a_used_in_heap, clk, rst_n, 1'b1, used_r <= OW'(HEAP_BYTES))
  `SFLA_ASSERT_NEXT(a_accept_to_check, clk, rst_n, in_valid && !in_stall, state_r == ST_CHECK)
  `SFLA_ASSERT_IMPLY(a_err_zero_addr, clk, rst_n, out_valid && out_status != sfla_pkg::ST_OK, out_payload_address == '0)
  `SFLA_ASSERT_IMPLY(a_cnt_idle, clk, rst_n, state_r != ST_CARVE, cnt_r == '0)

endmodule

/* tb/tb_segregated_free_list_allocator_core.sv */
module tb_segregated_free_list_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfla_pkg::*;

  localparam int HDR_BYTES        = HEADER_BYTES_DEF;
  localparam int SLAB_BLOCKS      = NUM_BLOCKS_DEF;
  localparam int HEAP_TOTAL       = HEAP_BYTES_DEF;
  localparam int HDR_SLOTS        = HEAP_BYTES_DEF / 8;
  localparam int RANDOM_PER_PHASE = 288;
  localparam int QUIET_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 24;
  localparam int NUM_ROWS         = 25;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           status;
  } grant_t;

  // limit < 0 leaves heap_limit alone; typed rows carry their own expected result
  typedef struct {
    int      limit;
    logic    op;
    int      size;
    int      addr;
    bit      typed;
    int      exp_addr;
    status_t exp_status;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [SIZE_W-1:0]   in_request_size = '0;
  logic [ADDR_W-1:0]   in_block_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ADDR_W-1:0]   out_payload_address;
  logic [STATUS_W-1:0] out_status;

  segregated_free_list_allocator_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_address (out_payload_address),
    .out_status          (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // allocator shadow state
  logic [CFG_W-1:0]   heap_budget = CFG_W'(LIMIT_RESET);
  logic [CFG_W-1:0]   carved_bytes = '0;
  logic [CFG_W-1:0]   list_head [NUM_CLASSES] = '{default: '0};
  logic [CLASS_W-1:0] hdr_class [HDR_SLOTS];
  logic [CFG_W-1:0]   hdr_link  [HDR_SLOTS];

  int     live_blocks[$];
  grant_t pending_grants[$];

  bit     row_typed = 1'b0;
  grant_t row_grant;
  int     send_idle_pct = 13;
  int     recv_idle_pct = 83;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     items_taken = 0;
  int     granted = 0;
  int     no_mem_seen = 0;
  int     too_large_seen = 0;
  int     frees_seen = 0;

  step_row_t directed_rows [NUM_ROWS] = '{
    '{-1,   OP_ALLOC, 0,   0,    1'b0, 0, ST_OK},
    '{0,    OP_ALLOC, 9,   0,    1'b1, 0, ST_NO_MEM},
    '{-1,   OP_ALLOC, 0,   0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 65,  0,    1'b1, 0, ST_TOO_LARGE},
    '{-1,   OP_ALLOC, 255, 1023, 1'b1, 0, ST_TOO_LARGE},
    '{-1,   OP_FREE,  0,   0,    1'b1, 0, ST_OK},
    '{-1,   OP_FREE,  255, 1023, 1'b1, 0, ST_OK},
    '{-1,   OP_FREE,  0,   15,   1'b1, 0, ST_OK},
    '{447,  OP_ALLOC, 16,  0,    1'b1, 0, ST_NO_MEM},
    '{448,  OP_ALLOC, 10,  0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 64,  0,    1'b1, 0, ST_NO_MEM},
    '{2047, OP_ALLOC, 17,  0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 32,  0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 33,  0,    1'b1, 0, ST_NO_MEM},
    '{-1,   OP_FREE,  0,   40,   1'b1, 0, ST_OK},
    '{-1,   OP_FREE,  0,   16,   1'b1, 0, ST_OK},
    '{-1,   OP_ALLOC, 1,   0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 8,   0,    1'b0, 0, ST_OK},
    '{-1,   OP_FREE,  0,   208,  1'b1, 0, ST_OK},
    '{-1,   OP_FREE,  0,   464,  1'b1, 0, ST_OK},
    '{-1,   OP_ALLOC, 20,  0,    1'b0, 0, ST_OK},
    '{-1,   OP_FREE,  0,   832,  1'b1, 0, ST_OK},
    '{-1,   OP_FREE,  0,   512,  1'b1, 0, ST_OK},
    '{-1,   OP_ALLOC, 11,  0,    1'b0, 0, ST_OK},
    '{-1,   OP_ALLOC, 0,   1023, 1'b0, 0, ST_OK}
  };

  int phase_limit [3] = '{1023, 1024, 2047};
  int phase_send  [3] = '{13, 83, 0};
  int phase_recv  [3] = '{83, 13, 0};

  function automatic int slot_of(input int hdr_offset);
    return ((hdr_offset >> 3) < HDR_SLOTS) ? (hdr_offset >> 3) : 0;
  endfunction

  function automatic grant_t compute_grant(input logic op, input logic [SIZE_W-1:0] size,
                                           input logic [ADDR_W-1:0] addr);
    grant_t g;
    int     cls, full, slab, cap, base, start, slot;
    g.address = '0;
    g.status  = ST_OK;
    if (op == OP_ALLOC) begin
      if (int'(size) > MAX_REQUEST) begin
        g.status = ST_TOO_LARGE;
      end else begin
        cls  = (size <= 8) ? 0 : (size <= 16) ? 1 : (size <= 32) ? 2 : 3;
        full = (8 << cls) + HDR_BYTES;
        slab = full * SLAB_BLOCKS;
        cap  = (int'(heap_budget) < HEAP_TOTAL) ? int'(heap_budget) : HEAP_TOTAL;
        base = int'(carved_bytes);
        // empty list: lay a slab at the top of the used heap and chain its blocks
        if (list_head[cls] == '0 && base + slab <= cap) begin
          for (int k = 0; k < SLAB_BLOCKS; k++) begin
            start = base + k * full;
            hdr_class[slot_of(start)] = CLASS_W'(cls);
            hdr_link[slot_of(start)]  = (k + 1 < SLAB_BLOCKS) ?
                                        CFG_W'(start + full + HDR_BYTES) : '0;
          end
          list_head[cls] = CFG_W'(base + HDR_BYTES);
          carved_bytes   = CFG_W'(base + slab);
        end
        if (list_head[cls] == '0) begin
          g.status = ST_NO_MEM;
        end else begin
          slot           = slot_of(int'(list_head[cls]) - HDR_BYTES);
          g.address      = ADDR_W'(list_head[cls]);
          list_head[cls] = hdr_link[slot];
          hdr_link[slot] = '0;
        end
      end
    end else if (addr != '0 && int'(addr) >= HDR_BYTES && int'(addr) < int'(carved_bytes)) begin
      slot = slot_of(int'(addr) - HDR_BYTES);
      hdr_link[slot] = list_head[hdr_class[slot]];
      list_head[hdr_class[slot]] = CFG_W'(addr);
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int expected, input int actual);
    $display("%0t ns  %s: expected %0d, got %0d", $time, what, expected, actual);
    mismatches++;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    grant_t g;
    grant_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        g = compute_grant(in_operation, in_request_size, in_block_address);
        items_taken++;
        if (in_operation == OP_FREE) begin
          frees_seen++;
          for (int i = 0; i < live_blocks.size(); i++)
            if (live_blocks[i] == int'(in_block_address)) begin
              live_blocks.delete(i);
              break;
            end
        end else if (g.status == ST_OK) begin
          granted++;
          live_blocks.push_back(int'(g.address));
        end else if (g.status == ST_NO_MEM) begin
          no_mem_seen++;
        end else begin
          too_large_seen++;
        end
        pending_grants.push_back(row_typed ? row_grant : g);
      end
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result with nothing outstanding", -1, int'(out_payload_address));
        end else begin
          want = pending_grants.pop_front();
          if (out_payload_address !== want.address)
            report_mismatch("payload_address", int'(want.address), int'(out_payload_address));
          if (out_status !== want.status)
            report_mismatch("status", int'(want.status), int'(out_status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("segregated_free_list_allocator_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered and left just after a falling edge
  task automatic drive_item(input logic op, input int size, input int addr,
                            input bit typed, input grant_t typed_grant);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_typed = typed;
    row_grant = typed_grant;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_request_size  <= SIZE_W'(size);
    in_block_address <= ADDR_W'(addr);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // only with the block drained, so the new limit cannot race an item
  task automatic write_limit(input int value);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    heap_budget = CFG_W'(value);
  endtask

  task automatic pick_random_item(output logic op, output int size, output int addr,
                                  output bit counted);
    int roll;
    roll    = $urandom_range(99);
    op      = OP_ALLOC;
    size    = $urandom_range(255);
    addr    = $urandom_range(1023);
    counted = 1'b1;
    if (roll < 45) begin
      size = ($urandom_range(99) < 80) ? $urandom_range(32) : $urandom_range(MAX_REQUEST, 33);
    end else if (roll < 85 && live_blocks.size() != 0) begin
      op   = OP_FREE;
      addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
    end else if (roll < 93) begin
      size = $urandom_range(255, MAX_REQUEST + 1);
    end else begin
      // frees the block drops: null, inside the first header, above the carved heap
      op      = OP_FREE;
      counted = 1'b0;
      case ($urandom_range(2))
        0:       addr = 0;
        1:       addr = $urandom_range(HDR_BYTES - 1, 1);
        default: addr = (int'(carved_bytes) < HEAP_TOTAL) ?
                        $urandom_range(HEAP_TOTAL - 1, int'(carved_bytes)) : 0;
      endcase
    end
  endtask

  initial begin
    step_row_t row;
    grant_t    g;
    logic      op;
    int        size, addr, done;
    bit        counted;
    g = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.limit >= 0) write_limit(row.limit);
      g.address = ADDR_W'(row.exp_addr);
      g.status  = row.exp_status;
      drive_item(row.op, row.size, row.addr, row.typed, g);
    end

    for (int phase = 0; phase < 3; phase++) begin
      write_limit(phase_limit[phase]);
      send_idle_pct = phase_send[phase];
      recv_idle_pct = phase_recv[phase];
      done = 0;
      while (done < RANDOM_PER_PHASE) begin
        pick_random_item(op, size, addr, counted);
        drive_item(op, size, addr, 1'b0, g);
        if (counted) done++;
      end
    end

    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d items (%0d table rows) over heap limits 0..2047, three idling mixes",
             items_taken, NUM_ROWS);
    $display("%0d grants, %0d out of heap, %0d oversize, %0d frees, %0d bytes carved",
             granted, no_mem_seen, too_large_seen, frees_seen, int'(carved_bytes));
    if (mismatches == 0) begin
      $display("segregated_free_list_allocator_core: match");
    end else begin
      $display("segregated_free_list_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
